FILE: rtl/decimal_event_counter_rate_meter_defines.svh
// Assertion macros shared by the RTL
`ifndef DECIMAL_EVENT_COUNTER_RATE_METER_DEFINES_SVH
`define DECIMAL_EVENT_COUNTER_RATE_METER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define DECM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("decm: implication check failed");
// next-cycle implication
`define DECM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("decm: next-cycle check failed");
`else
`define DECM_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define DECM_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/decm_pkg.sv
package decm_pkg;

   // parameter defaults
   localparam int MAX_DISPLAY_DIGITS_DEF = 13;
   localparam int RING_DEPTH_DEF         = 200;
   localparam int TICKS_PER_SECOND_DEF   = 1000000;

   // datapath widths
   localparam int SAMPLE_W   = 60;   // 52.8 rate sample
   localparam int DIV_W      = 68;   // dividend / quotient of the shared divider
   localparam int DEN_W      = 32;   // divisor width
   localparam int CONV_W     = 53;   // binary value fed to the BCD converter
   localparam int BCD_DIGITS = 16;
   localparam int TOTAL_W    = 44;
   localparam int CODE_POS   = 13;
   localparam int CODES_W    = 4 * CODE_POS;
   localparam int STEP_W     = 7;

   // display codes
   localparam logic [3:0]         CODE_UNIT  = 4'd10;
   localparam logic [3:0]         CODE_BLANK = 4'd11;
   localparam logic [CODES_W-1:0] ALL_BLANK  = 52'hBBBBBBBBBBBBB;

   // register indexes
   localparam logic [2:0] CSR_NUM_DIGITS    = 3'd0;
   localparam logic [2:0] CSR_POWER_ON      = 3'd1;
   localparam logic [2:0] CSR_COUNT_MODE    = 3'd2;
   localparam logic [2:0] CSR_HOLD_DISPLAY  = 3'd3;
   localparam logic [2:0] CSR_SMOOTHING_LEN = 3'd4;

   // 10^d for d = 0..13
   function automatic logic [TOTAL_W-1:0] pow_ten(input logic [3:0] d);
      logic [TOTAL_W-1:0] v;
      case (d)
         4'd0:    v = 44'd1;
         4'd1:    v = 44'd10;
         4'd2:    v = 44'd100;
         4'd3:    v = 44'd1000;
         4'd4:    v = 44'd10000;
         4'd5:    v = 44'd100000;
         4'd6:    v = 44'd1000000;
         4'd7:    v = 44'd10000000;
         4'd8:    v = 44'd100000000;
         4'd9:    v = 44'd1000000000;
         4'd10:   v = 44'd10000000000;
         4'd11:   v = 44'd100000000000;
         4'd12:   v = 44'd1000000000000;
         default: v = 44'd10000000000000;
      endcase
      return v;
   endfunction

endpackage

FILE: rtl/decimal_event_counter_rate_meter.sv
// An update with zero ticks skips to the BCD conversion; one with ticks runs two 68-step divisions,
// a sweep over the n-slot ring (n = smoothing length) and the 53-step BCD conversion.
// Throughput: one word at a time; req_tready is high only while the sequencer idles, and an
// untaken response holds the sequencer in its last state. Reset request words give no response.
// Synchronous active-high reset: config to defaults, total 0, reset pending set, ring reads zero
// (valid bits), display blank.
`include "decimal_event_counter_rate_meter_defines.svh"

module decimal_event_counter_rate_meter
   import decm_pkg::*;
#(
   parameter int MAX_DISPLAY_DIGITS = MAX_DISPLAY_DIGITS_DEF,
   parameter int RING_DEPTH         = RING_DEPTH_DEF,
   parameter int TICKS_PER_SECOND   = TICKS_PER_SECOND_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // batch_count[31:0], elapsed_ticks[63:32]
   input  logic        req_tuser,   // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // display_codes[51:0], total_value[95:52]
   output logic [1:0]  rsp_tuser,   // display_changed[0], in_range[1]
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [7:0]  csr_wdata
);

   localparam int RING_AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int TPS_W   = $clog2(TICKS_PER_SECOND + 1);
   localparam int PROD_W  = 32 + TPS_W;
   localparam logic [TPS_W-1:0] TPS_C = TPS_W'(TICKS_PER_SECOND);

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_MUL   = 10'b0000000010,
      S_DIV1  = 10'b0000000100,
      S_WRITE = 10'b0000001000,
      S_SUM   = 10'b0000010000,
      S_DIV2  = 10'b0000100000,
      S_ROUND = 10'b0001000000,
      S_TOTAL = 10'b0010000000,
      S_CONV  = 10'b0100000000,
      S_OUT   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   // config
   logic [3:0] num_digits_ff;
   logic       power_on_ff, count_mode_ff, hold_display_ff;
   logic [7:0] smoothing_len_ff;

   // item and status
   logic [31:0]         counts_ff, ticks_ff;
   logic [TOTAL_W-1:0]  total_ff;
   logic                pending_ff;
   logic [7:0]          ring_slot_ff;
   logic [CODES_W-1:0]  shown_ff;
   logic [CONV_W-1:0]   rate_ff;
   logic                ok_ff;

   // shared divider
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in, den_ff;
   logic [DEN_W:0]   rem_sh;
   logic             div_ge;
   logic [STEP_W-1:0] step_ff;

   // ring and sweep
   logic [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
   logic [RING_DEPTH-1:0] ring_valid_ff;
   logic [SAMPLE_W-1:0] rd_data_ff;
   logic                rd_valid_ff, rd_live_ff;
   logic [8:0]          sweep_ff;
   logic [DIV_W-1:0]    acc_ff;
   logic                rd_en, wr_en;

   // BCD converter
   logic [CONV_W-1:0]         conv_ff;
   logic [4*BCD_DIGITS-1:0]   bcd_ff, bcd_adj;

   // response
   logic               rsp_valid_ff, rsp_changed_ff, rsp_ok_ff;
   logic [CODES_W-1:0] rsp_codes_ff;
   logic [TOTAL_W-1:0] rsp_total_ff;

   // effective config
   logic [3:0]        eff_d;
   logic [7:0]        eff_n;
   logic [TOTAL_W-1:0] lim;
   logic [PROD_W-1:0] prod;
   logic [8:0]        slot_nxt;
   logic [TOTAL_W:0]  total_sum;
   logic [SAMPLE_W:0] round_sum;
   logic              req_acc, out_go;
   logic [CODES_W-1:0] cnt_codes, act_codes;

   always_comb begin
      if (num_digits_ff == 4'd0) begin
         eff_d = 4'd1;
      end else if (32'(num_digits_ff) > MAX_DISPLAY_DIGITS) begin
         eff_d = 4'(MAX_DISPLAY_DIGITS);
      end else begin
         eff_d = num_digits_ff;
      end
      if (smoothing_len_ff == 8'd0) begin
         eff_n = 8'd1;
      end else if ({1'b0, smoothing_len_ff} > 9'(RING_DEPTH)) begin
         eff_n = 8'(RING_DEPTH);
      end else begin
         eff_n = smoothing_len_ff;
      end
   end

   assign lim        = pow_ten(eff_d);
   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign out_go     = !rsp_valid_ff || rsp_tready;
   assign prod       = PROD_W'(counts_ff) * PROD_W'(TPS_C);
   assign slot_nxt   = {1'b0, ring_slot_ff} + 9'd1;
   assign round_sum  = {1'b0, quo_ff[SAMPLE_W-1:0]} + (SAMPLE_W+1)'(128);
   assign total_sum  = {1'b0, total_ff}
                     + ((pending_ff && hold_display_ff) ? '0 : (TOTAL_W+1)'(counts_ff));

   // divider step: shift in one dividend bit, subtract when it fits
   assign rem_sh = {rem_ff, quo_ff[DIV_W-1]};
   assign div_ge = (rem_sh >= {1'b0, den_ff});
   assign rem_in = div_ge ? DEN_W'(rem_sh - {1'b0, den_ff}) : rem_sh[DEN_W-1:0];
   assign quo_in = {quo_ff[DIV_W-2:0], div_ge};

   // double-dabble adjust
   always_comb begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
         bcd_adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ? bcd_ff[4*i +: 4] + 4'd3
                                                        : bcd_ff[4*i +: 4];
      end
   end

   // display images
   always_comb begin
      for (int p = 0; p < CODE_POS; p++) begin
         cnt_codes[4*p +: 4] = (4'(p) < eff_d) ? bcd_ff[4*p +: 4] : CODE_BLANK;
         if (p == 0) begin
            act_codes[3:0] = CODE_UNIT;
         end else begin
            act_codes[4*p +: 4] = (4'(p) < eff_d) ? bcd_ff[4*(p-1) +: 4] : CODE_BLANK;
         end
      end
   end

   // ring port controls
   assign wr_en = (state_ff == S_WRITE) && ({1'b0, ring_slot_ff} < 9'(RING_DEPTH));
   assign rd_en = (state_ff == S_SUM) && (sweep_ff < {1'b0, eff_n});

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_acc && !req_tuser) state_in = S_MUL;
         S_MUL:   state_in = (ticks_ff == 32'd0) ? S_TOTAL : S_DIV1;
         S_DIV1:  if (step_ff == STEP_W'(DIV_W-1)) state_in = S_WRITE;
         S_WRITE: state_in = S_SUM;
         S_SUM:   if (!rd_en && !rd_live_ff) state_in = S_DIV2;
         S_DIV2:  if (step_ff == STEP_W'(DIV_W-1)) state_in = S_ROUND;
         S_ROUND: state_in = S_TOTAL;
         S_TOTAL: state_in = S_CONV;
         S_CONV:  if (step_ff == STEP_W'(CONV_W-1)) state_in = S_OUT;
         S_OUT:   if (out_go) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // ring memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[ring_slot_ff[RING_AW-1:0]] <= quo_ff[SAMPLE_W-1:0];
      end
      if (rd_en) begin
         rd_data_ff <= ring_mem[sweep_ff[RING_AW-1:0]];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         num_digits_ff    <= 4'd6;
         power_on_ff      <= 1'b1;
         count_mode_ff    <= 1'b1;
         hold_display_ff  <= 1'b0;
         smoothing_len_ff <= 8'd1;
         total_ff         <= '0;
         pending_ff       <= 1'b1;
         ring_slot_ff     <= '0;
         ring_valid_ff    <= '0;
         shown_ff         <= ALL_BLANK;
         rsp_valid_ff     <= 1'b0;
         rd_live_ff       <= 1'b0;
      end else begin
         state_ff <= state_in;

         // config writes
         if (csr_we) begin
            unique case (csr_addr)
               CSR_NUM_DIGITS:    num_digits_ff    <= csr_wdata[3:0];
               CSR_POWER_ON:      power_on_ff      <= csr_wdata[0];
               CSR_COUNT_MODE:    count_mode_ff    <= csr_wdata[0];
               CSR_HOLD_DISPLAY:  hold_display_ff  <= csr_wdata[0];
               CSR_SMOOTHING_LEN: smoothing_len_ff <= csr_wdata;
               default: ;
            endcase
         end

         if (req_acc && req_tuser) begin
            pending_ff <= 1'b1;
         end

         // sample store and slot advance
         if (state_ff == S_WRITE) begin
            if (wr_en) begin
               ring_valid_ff[ring_slot_ff[RING_AW-1:0]] <= 1'b1;
            end
            ring_slot_ff <= (slot_nxt >= {1'b0, eff_n}) ? 8'd0 : slot_nxt[7:0];
         end

         rd_live_ff <= rd_en;

         if (state_ff == S_TOTAL && power_on_ff) begin
            if (total_sum >= {1'b0, lim} || pending_ff) begin
               total_ff <= '0;
            end else begin
               total_ff <= total_sum[TOTAL_W-1:0];
            end
         end

         // display update and response
         if (state_ff == S_OUT && out_go) begin
            rsp_valid_ff <= 1'b1;
            rsp_total_ff <= total_ff;
            if (!power_on_ff) begin
               shown_ff       <= ALL_BLANK;
               rsp_codes_ff   <= ALL_BLANK;
               rsp_changed_ff <= 1'b1;
            end else if (count_mode_ff) begin
               if (!hold_display_ff || pending_ff) begin
                  shown_ff       <= cnt_codes;
                  rsp_codes_ff   <= cnt_codes;
                  rsp_changed_ff <= 1'b1;
               end else begin
                  rsp_codes_ff   <= shown_ff;
                  rsp_changed_ff <= 1'b0;
               end
            end else begin
               if (ok_ff || pending_ff) begin
                  shown_ff       <= act_codes;
                  rsp_codes_ff   <= act_codes;
                  rsp_changed_ff <= 1'b1;
               end else begin
                  rsp_codes_ff   <= shown_ff;
                  rsp_changed_ff <= 1'b0;
               end
            end
            rsp_ok_ff <= ok_ff;
            if (!hold_display_ff) begin
               pending_ff <= 1'b0;
            end
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (req_acc) begin
         counts_ff <= req_tdata[31:0];
         ticks_ff  <= req_tdata[63:32];
      end
      rd_valid_ff <= ring_valid_ff[sweep_ff[RING_AW-1:0]];

      unique case (state_ff)
         S_MUL: begin
            quo_ff  <= DIV_W'({prod, 8'd0});
            rem_ff  <= '0;
            den_ff  <= ticks_ff;
            step_ff <= '0;
            rate_ff <= '0;
         end
         S_DIV1, S_DIV2: begin
            quo_ff  <= quo_in;
            rem_ff  <= rem_in;
            step_ff <= step_ff + STEP_W'(1);
         end
         S_WRITE: begin
            sweep_ff <= '0;
            acc_ff   <= '0;
         end
         S_SUM: begin
            if (rd_en) begin
               sweep_ff <= sweep_ff + 9'd1;
            end
            if (rd_live_ff && rd_valid_ff) begin
               acc_ff <= acc_ff + DIV_W'(rd_data_ff);
            end
            if (!rd_en && !rd_live_ff) begin
               quo_ff  <= acc_ff;
               rem_ff  <= '0;
               den_ff  <= DEN_W'(eff_n);
               step_ff <= '0;
            end
         end
         S_ROUND: rate_ff <= round_sum[SAMPLE_W:8];
         S_TOTAL: begin
            ok_ff   <= !power_on_ff || count_mode_ff
                       || (rate_ff < CONV_W'(lim));
            // converter input: rate, or the total as it stands after this word
            if (!count_mode_ff) begin
               conv_ff <= rate_ff;
            end else if (!power_on_ff) begin
               conv_ff <= CONV_W'(total_ff);
            end else if (total_sum >= {1'b0, lim} || pending_ff) begin
               conv_ff <= '0;
            end else begin
               conv_ff <= CONV_W'(total_sum[TOTAL_W-1:0]);
            end
            bcd_ff  <= '0;
            step_ff <= '0;
         end
         S_CONV: begin
            bcd_ff  <= {bcd_adj[4*BCD_DIGITS-2:0], conv_ff[CONV_W-1]};
            conv_ff <= {conv_ff[CONV_W-2:0], 1'b0};
            step_ff <= step_ff + STEP_W'(1);
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_total_ff, rsp_codes_ff};
   assign rsp_tuser  = {rsp_ok_ff, rsp_changed_ff};

   // checks
   `DECM_ASSERT_NXT(a_reset_req_pending, clock, reset, req_acc && req_tuser, pending_ff)
   `DECM_ASSERT_IMP(a_slot_in_ring, clock, reset, 1'b1, {1'b0, ring_slot_ff} < 9'(RING_DEPTH))
   `DECM_ASSERT_IMP(a_rsp_from_out, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == S_OUT)
   `DECM_ASSERT_IMP(a_off_blank, clock, reset, rsp_valid_ff && !power_on_ff,
                    rsp_codes_ff == ALL_BLANK)
   `DECM_ASSERT_IMP(a_sweep_bound, clock, reset, state_ff == S_SUM,
                    sweep_ff <= {1'b0, eff_n})

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import decm_pkg::*;

   localparam int TPS        = 1000000;
   localparam int RING_SLOTS = 200;
   localparam int MAX_DIG    = 13;
   localparam int SETTLE     = 500;     // cycles after the last response
   localparam int IDLE_LIMIT = 40000;   // cycles without any word moving
   localparam int RAND_WORDS = 1080;

   typedef enum logic {ACT_UPDATE = 1'b0, ACT_RESET = 1'b1} action_e;
   typedef enum logic {ROW_WORD, ROW_CSR} row_e;

   typedef struct packed {
      logic [CODES_W-1:0] codes;
      logic               changed;
      logic               in_range;
      logic [TOTAL_W-1:0] total;
   } meter_out_t;

   typedef struct {
      row_e       kind;
      action_e    act;
      logic [31:0] counts;   // csr data for ROW_CSR
      logic [31:0] ticks;    // csr index for ROW_CSR
      bit         typed;
      meter_out_t want;
   } stim_row_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_addr = '0;
   logic [7:0]  csr_wdata = '0;

   decimal_event_counter_rate_meter u_top (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // register mirror
   logic [3:0] cfg_digits;
   logic       cfg_power, cfg_count, cfg_hold;
   logic [7:0] cfg_smooth;

   // meter state mirror
   logic [TOTAL_W-1:0]  tot;
   logic                pend;
   logic [SAMPLE_W-1:0] ring [RING_SLOTS];
   int unsigned         slot;
   logic [CODES_W-1:0]  shown;

   meter_out_t expected_q[$];
   int         mismatches = 0;
   int         responses = 0;
   bit         typed_armed = 0;
   meter_out_t typed_want;

   function automatic logic [43:0] ten_pow(int d);
      logic [43:0] v = 1;
      for (int i = 0; i < d; i++) v = v * 10;
      return v;
   endfunction

   // lowest cnt decimal digits of v placed from position base, blank elsewhere
   function automatic logic [CODES_W-1:0] digit_codes(logic [63:0] v, int base, int cnt,
                                                      int used);
      logic [CODES_W-1:0] c;
      logic [63:0]        w;
      c = ALL_BLANK;
      w = v;
      for (int p = 0; p < CODE_POS; p++) begin
         if (p < used && p >= base && p - base < cnt) begin
            c[4*p +: 4] = 4'(w % 10);
            w = w / 10;
         end
      end
      return c;
   endfunction

   function automatic void meter_reset();
      cfg_digits = 4'd6; cfg_power = 1; cfg_count = 1; cfg_hold = 0; cfg_smooth = 8'd1;
      tot = '0; pend = 1; slot = 0; shown = ALL_BLANK;
      for (int i = 0; i < RING_SLOTS; i++) ring[i] = '0;
   endfunction

   // advance the mirror by one update word and return the display it produces
   function automatic meter_out_t meter_update(logic [31:0] counts, logic [31:0] ticks);
      meter_out_t  r;
      int          d, n;
      logic [63:0] smp, rate;
      logic [71:0] sum;
      d = (cfg_digits == 0) ? 1 : (cfg_digits > MAX_DIG ? MAX_DIG : cfg_digits);
      n = (cfg_smooth == 0) ? 1 : (cfg_smooth > RING_SLOTS ? RING_SLOTS : cfg_smooth);
      rate = 0;
      r.changed = 0;
      r.in_range = 1;
      if (ticks != 0) begin
         smp = (64'(counts) * 64'(TPS)) << 8;
         smp = smp / ticks;
         ring[slot] = smp[SAMPLE_W-1:0];
         slot++;
         if (slot >= n) slot = 0;
         sum = '0;
         for (int k = 0; k < n; k++) sum += ring[k];
         rate = 64'(((sum / n) + 128) >> 8);
      end
      if (!cfg_power) begin
         shown = ALL_BLANK;
         r.changed = 1;
      end else begin
         if (!(pend && cfg_hold)) tot = tot + counts;
         if (tot >= ten_pow(d) || pend) tot = '0;
         if (cfg_count) begin
            if (!cfg_hold || pend) begin
               shown = digit_codes(64'(tot), 0, d, d);
               r.changed = 1;
            end
         end else begin
            r.in_range = (rate < 64'(ten_pow(d)));
            if (r.in_range || pend) begin
               shown = digit_codes(rate, 1, d - 1, d);
               shown[3:0] = CODE_UNIT;
               r.changed = 1;
            end
         end
      end
      if (!cfg_hold) pend = 0;
      r.codes = shown;
      r.total = tot;
      return r;
   endfunction

   // prediction on accepted words, checking on accepted responses
   always @(posedge clock) begin
      meter_out_t p, got;
      if (!reset && req_tvalid && req_tready) begin
         if (req_tuser == ACT_RESET) begin
            pend = 1;
         end else begin
            p = meter_update(req_tdata[31:0], req_tdata[63:32]);
            if (typed_armed) begin
               p = typed_want;
               typed_armed = 0;
            end
            expected_q.push_back(p);
         end
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         responses++;
         got.codes    = rsp_tdata[51:0];
         got.total    = rsp_tdata[95:52];
         got.changed  = rsp_tuser[0];
         got.in_range = rsp_tuser[1];
         if (expected_q.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected response codes=%h total=%0d", $time, got.codes,
                     got.total);
         end else begin
            p = expected_q.pop_front();
            if (got.codes != p.codes) begin
               mismatches++;
               $display("%0t: display_codes expected %h actual %h", $time, p.codes, got.codes);
            end
            if (got.changed != p.changed) begin
               mismatches++;
               $display("%0t: display_changed expected %0d actual %0d", $time, p.changed,
                        got.changed);
            end
            if (got.in_range != p.in_range) begin
               mismatches++;
               $display("%0t: in_range expected %0d actual %0d", $time, p.in_range,
                        got.in_range);
            end
            if (got.total != p.total) begin
               mismatches++;
               $display("%0t: total_value expected %0d actual %0d", $time, p.total, got.total);
            end
         end
      end
   end

   // watchdog on cycles with no word moving
   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // receiver: random ready runs, one long hold-off once traffic is flowing
   initial begin
      int run;
      bit long_done;
      long_done = 0;
      @(negedge clock);
      forever begin
         if (!long_done && responses >= 300) begin
            long_done = 1;
            rsp_tready <= 1'b0;
            repeat (3000) @(negedge clock);
         end
         case ($urandom_range(0, 3))
            0: begin rsp_tready <= 1'b0; run = $urandom_range(1, 300); end
            1: begin rsp_tready <= 1'b1; run = $urandom_range(50, 2000); end
            default: begin rsp_tready <= 1'($urandom); run = $urandom_range(1, 8); end
         endcase
         repeat (run) @(negedge clock);
      end
   end

   // sender burst state
   int burst_left = 0;

   // offer one word; valid stays up into the next word of a burst
   task automatic send_word(action_e act, logic [31:0] counts, logic [31:0] ticks);
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {ticks, counts};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(0, 40)) @(negedge clock);
         burst_left = $urandom_range(0, 12);
      end
   endtask

   // wait until the block is idle, then write one register
   task automatic csr_write(logic [2:0] idx, logic [7:0] val);
      req_tvalid <= 1'b0;
      wait (expected_q.size() == 0);
      repeat (SETTLE) @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_NUM_DIGITS:    cfg_digits = val[3:0];
         CSR_POWER_ON:      cfg_power  = val[0];
         CSR_COUNT_MODE:    cfg_count  = val[0];
         CSR_HOLD_DISPLAY:  cfg_hold   = val[0];
         CSR_SMOOTHING_LEN: cfg_smooth = val;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic stim_row_t upd(logic [31:0] c, logic [31:0] t);
      stim_row_t r;
      r.kind = ROW_WORD; r.act = ACT_UPDATE; r.counts = c; r.ticks = t; r.typed = 0;
      r.want = '0;
      return r;
   endfunction

   function automatic stim_row_t upd_t(logic [31:0] c, logic [31:0] t,
                                       logic [CODES_W-1:0] codes, logic [43:0] total);
      stim_row_t r;
      r = upd(c, t);
      r.typed = 1;
      r.want.codes = codes; r.want.changed = 1; r.want.in_range = 1; r.want.total = total;
      return r;
   endfunction

   function automatic stim_row_t rst_req();
      stim_row_t r;
      r = upd(0, 0);
      r.act = ACT_RESET;
      return r;
   endfunction

   function automatic stim_row_t csr(logic [2:0] idx, logic [7:0] val);
      stim_row_t r;
      r = upd(32'(val), 32'(idx));
      r.kind = ROW_CSR;
      return r;
   endfunction

   function automatic logic [31:0] rand_field(bit is_ticks);
      case ($urandom_range(0, 9))
         0: return is_ticks ? 32'd0 : 32'hFFFF_FFFF;
         1: return 32'hFFFF_FFFF;
         2, 3: return $urandom_range(0, 20);
         4, 5: return is_ticks ? $urandom_range(100000, 5000000) : $urandom_range(0, 2000);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      stim_row_t rows[$];
      int        sent;
      meter_reset();
      // directed: reset behavior, wrap, hold, rate extremes, clamps, power off
      rows.push_back(upd_t(32'd5, 32'd0, 52'hBBBBBBB000000, 44'd0));
      rows.push_back(upd_t(32'd7, 32'd0, 52'hBBBBBBB000007, 44'd7));
      rows.push_back(upd_t(32'hFFFF_FFFF, 32'd1, 52'hBBBBBBB000000, 44'd0));
      rows.push_back(rst_req());
      rows.push_back(upd(32'd3, 32'd1000000));
      rows.push_back(csr(CSR_HOLD_DISPLAY, 8'd1));
      rows.push_back(rst_req());
      rows.push_back(upd(32'd9, 32'd10));
      rows.push_back(upd(32'd9, 32'd10));
      rows.push_back(csr(CSR_HOLD_DISPLAY, 8'd0));
      rows.push_back(csr(CSR_COUNT_MODE, 8'd0));
      rows.push_back(csr(CSR_NUM_DIGITS, 8'd13));
      rows.push_back(csr(CSR_SMOOTHING_LEN, 8'd200));
      rows.push_back(upd(32'hFFFF_FFFF, 32'd1));
      rows.push_back(upd(32'd0, 32'hFFFF_FFFF));
      rows.push_back(upd(32'd1, 32'd0));
      rows.push_back(csr(CSR_NUM_DIGITS, 8'd1));
      rows.push_back(upd(32'd12, 32'd1000000));
      rows.push_back(csr(CSR_HOLD_DISPLAY, 8'd1));
      rows.push_back(upd(32'd5, 32'd1000000));
      rows.push_back(rst_req());
      rows.push_back(upd(32'd50, 32'd1000000));
      rows.push_back(csr(CSR_SMOOTHING_LEN, 8'd0));
      rows.push_back(csr(CSR_NUM_DIGITS, 8'd0));
      rows.push_back(upd(32'd0, 32'd1));
      rows.push_back(csr(CSR_NUM_DIGITS, 8'd15));
      rows.push_back(csr(CSR_SMOOTHING_LEN, 8'd255));
      rows.push_back(upd(32'd1234, 32'd7));
      rows.push_back(csr(CSR_POWER_ON, 8'd0));
      rows.push_back(upd(32'd100, 32'd100));
      rows.push_back(csr(CSR_POWER_ON, 8'd1));
      rows.push_back(csr(CSR_HOLD_DISPLAY, 8'd0));
      rows.push_back(csr(CSR_COUNT_MODE, 8'd1));
      rows.push_back(csr(CSR_NUM_DIGITS, 8'd14));
      rows.push_back(upd(32'hFFFF_FFFF, 32'hFFFF_FFFF));
      rows.push_back(upd(32'hAAAA_AAAA, 32'h5555_5555));

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         if (rows[i].kind == ROW_CSR) begin
            csr_write(rows[i].ticks[2:0], rows[i].counts[7:0]);
         end else begin
            typed_armed = rows[i].typed;
            typed_want  = rows[i].want;
            send_word(rows[i].act, rows[i].counts, rows[i].ticks);
         end
      end

      // random phases with a fresh register setting each
      sent = 0;
      while (sent < RAND_WORDS) begin
         csr_write(CSR_NUM_DIGITS, ($urandom_range(0, 3) == 0) ?
                   8'($urandom_range(0, 15)) : 8'($urandom_range(1, 13)));
         csr_write(CSR_POWER_ON, 8'($urandom_range(0, 7) != 0));
         csr_write(CSR_COUNT_MODE, 8'($urandom_range(0, 1)));
         csr_write(CSR_HOLD_DISPLAY, 8'($urandom_range(0, 3) == 0));
         csr_write(CSR_SMOOTHING_LEN, ($urandom_range(0, 3) == 0) ?
                   8'($urandom) : 8'($urandom_range(0, 8)));
         repeat ($urandom_range(20, 90)) begin
            if ($urandom_range(0, 11) == 0)
               send_word(ACT_RESET, $urandom, $urandom);
            else
               send_word(ACT_UPDATE, rand_field(0), rand_field(1));
            sent++;
         end
      end

      req_tvalid <= 1'b0;
      wait (expected_q.size() == 0);
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
